// File: sv/kap_pkg.sv
// Package for the keypad alarm panel controller.
// Holds the mode, key and event codes and the state and result structs.
// Used by kap_next and keypad_alarm_panel_controller.
`default_nettype none

package kap_pkg;

  localparam int unsigned CodeW  = 14;
  localparam int unsigned CountW = 3;

  // Digits in a code; kept below 8 so the count fits its field.
  localparam logic [CountW-1:0] CODE_DIGITS = 3'd4;
  localparam logic [CodeW-1:0]  RESET_CODE  = 14'd1234;

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_ARM_ENTRY    = 3'd1,
    MODE_PROGRAM      = 3'd2,
    MODE_ZONES        = 3'd3,
    MODE_CHANGE       = 3'd4,
    MODE_ARMED        = 3'd5,
    MODE_DISARM_ENTRY = 3'd6,
    MODE_ALARMED      = 3'd7
  } mode_t;

  localparam logic [3:0] KEY_F1    = 4'd10;
  localparam logic [3:0] KEY_F2    = 4'd11;
  localparam logic [3:0] KEY_F3    = 4'd12;
  localparam logic [3:0] KEY_DIGIT_LIMIT = 4'd10;

  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_ACCEPT  = 2'd1,
    EV_REJECT  = 2'd2,
    EV_CHANGED = 2'd3
  } event_t;

  typedef struct packed {
    mode_t             mode;
    logic [CodeW-1:0]  stored_code;
    logic [CodeW-1:0]  entry_acc;
    logic [CodeW-1:0]  new_acc;
    logic [CountW-1:0] digit_count;
    logic              intrusion;
    logic [3:0]        lamps;
    logic              buzzer;
    logic              relay;
  } kap_state_t;

  typedef struct packed {
    logic [2:0]       panel_mode;
    logic [CodeW-1:0] entered_value;
    logic [1:0]       event_code;
    logic [3:0]       zone_lamps;
    logic             buzzer_drive;
    logic             alarm_relays;
  } kap_result_t;

endpackage

`default_nettype wire

// File: sv/keypad_alarm_panel_controller.sv
// Keypad alarm panel controller: top level with panel state and result buffer.
// Depends on kap_pkg and kap_next.
//
// Usage:
//   Input channel (in_*): one item per keypad/sensor scan tick, carrying the
//   key code and the eight sensor and panic bits. Accepted on a clock edge
//   with in_valid high and in_stall low.
//   Result channel (out_*): exactly one result item per input item, in order,
//   carrying the panel mode after the tick, the typed value, the event code,
//   the zone lamps, buzzer and relay drives.
//   A result is registered on out_*, or in the skid register if out_* is held.
//   Throughput: one item per cycle while in_stall is low; the panel state
//   updates in the accept cycle, so the next tick may follow immediately.
//   Stall: a result held by out_stall stays on the port; one more result is
//   kept in a skid register, and in_stall rises only when that register is
//   full. in_stall is a register output and never depends on in_valid.
//   Reset (rst_n low, synchronous): panel idle, stored code 1234, all
//   accumulators, counts, flags and drives cleared, both result slots empty.
`default_nettype none

module keypad_alarm_panel_controller (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_key_code,
  input  logic       in_door_sensor,
  input  logic       in_dining_window,
  input  logic       in_dining_motion,
  input  logic       in_kitchen_window,
  input  logic       in_kitchen_motion,
  input  logic       in_bedroom_window,
  input  logic       in_bathroom_window,
  input  logic       in_panic_button,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_panel_mode,
  output logic [kap_pkg::CodeW-1:0] out_entered_value,
  output logic [1:0] out_event_code,
  output logic [3:0] out_zone_lamps,
  output logic       out_buzzer_drive,
  output logic       out_alarm_relays
);
  import kap_pkg::*;

  kap_state_t  state_r;
  kap_state_t  state_nxt;
  kap_result_t res_nxt;
  kap_result_t out_r;
  kap_result_t skid_r;
  logic        out_valid_r;
  logic        skid_valid_r;
  logic [3:0]  zones;
  logic        in_accept;
  logic        out_free;

  assign zones = {in_bathroom_window,
                  in_bedroom_window,
                  in_kitchen_window | in_kitchen_motion,
                  in_door_sensor | in_dining_window | in_dining_motion};

  kap_next u_next (
    .cur      (state_r),
    .key_code (in_key_code),
    .zones    (zones),
    .panic    (in_panic_button),
    .nxt      (state_nxt),
    .res      (res_nxt)
  );

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.mode        <= MODE_IDLE;
      state_r.stored_code <= RESET_CODE;
      state_r.entry_acc   <= '0;
      state_r.new_acc     <= '0;
      state_r.digit_count <= '0;
      state_r.intrusion   <= 1'b0;
      state_r.lamps       <= '0;
      state_r.buzzer      <= 1'b0;
      state_r.relay       <= 1'b0;
    end else if (in_accept) begin
      state_r <= state_nxt;
    end
  end

  // Two-slot result buffer: output register plus skid register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (in_accept) begin
        out_r <= res_nxt;
      end
    end else if (in_accept) begin
      skid_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_panel_mode    = out_r.panel_mode;
  assign out_entered_value = out_r.entered_value;
  assign out_event_code    = out_r.event_code;
  assign out_zone_lamps    = out_r.zone_lamps;
  assign out_buzzer_drive  = out_r.buzzer_drive;
  assign out_alarm_relays  = out_r.alarm_relays;

endmodule

`default_nettype wire

// File: sv/kap_next.sv
// Next-state and result logic for one scan tick of the alarm panel.
// Purely combinational; depends on kap_pkg for modes, codes and structs.
`default_nettype none

module kap_next (
  input  kap_pkg::kap_state_t  cur,
  input  logic [3:0]           key_code,
  input  logic [3:0]           zones,
  input  logic                 panic,
  output kap_pkg::kap_state_t  nxt,
  output kap_pkg::kap_result_t res
);
  import kap_pkg::*;

  logic              digit_ok;
  logic [CodeW-1:0]  acc_in;
  logic [CodeW-1:0]  acc_step;
  logic [CountW-1:0] cnt_step;
  logic              done;
  logic              took;
  event_t            ev;
  logic [CodeW-1:0]  shown;

  assign digit_ok = (cur.digit_count < CODE_DIGITS) && (key_code < KEY_DIGIT_LIMIT);
  assign acc_in   = (cur.mode == MODE_CHANGE) ? cur.new_acc : cur.entry_acc;
  // acc * 10 + key, kept to 14 bits
  assign acc_step = {acc_in[CodeW-4:0], 3'b000} + {acc_in[CodeW-2:0], 1'b0}
                  + {{(CodeW-4){1'b0}}, key_code};
  assign cnt_step = cur.digit_count + 3'd1;
  assign done     = (cnt_step == CODE_DIGITS);

  always_comb begin
    nxt  = cur;
    took = 1'b0;
    ev   = EV_NONE;
    unique case (cur.mode)
      MODE_IDLE: begin
        if (key_code == KEY_F1) begin
          nxt.lamps[0] = 1'b0;
          nxt.mode     = MODE_ARM_ENTRY;
        end else if (key_code == KEY_F2) begin
          nxt.lamps[0] = 1'b0;
          nxt.mode     = MODE_PROGRAM;
        end
      end
      MODE_PROGRAM: begin
        if (key_code == KEY_F1) begin
          nxt.lamps[0] = 1'b0;
          nxt.mode     = MODE_ZONES;
        end else if (key_code == KEY_F2) begin
          nxt.lamps[0] = 1'b0;
          nxt.mode     = MODE_CHANGE;
        end else if (key_code == KEY_F3) begin
          nxt.lamps[0] = 1'b0;
          nxt.mode     = MODE_IDLE;
        end
      end
      MODE_ZONES: begin
        nxt.lamps[2] = 1'b1;
        nxt.mode     = MODE_PROGRAM;
      end
      MODE_CHANGE: begin
        if (digit_ok) begin
          took            = 1'b1;
          nxt.new_acc     = acc_step;
          nxt.digit_count = cnt_step;
          if (done) begin
            nxt.stored_code = acc_step;
            nxt.new_acc     = '0;
            nxt.digit_count = '0;
            ev              = EV_CHANGED;
            nxt.mode        = MODE_PROGRAM;
          end
        end
      end
      MODE_ARM_ENTRY: begin
        if (digit_ok) begin
          took            = 1'b1;
          nxt.entry_acc   = acc_step;
          nxt.digit_count = cnt_step;
          if (done) begin
            nxt.entry_acc   = '0;
            nxt.digit_count = '0;
            nxt.intrusion   = 1'b0;
            nxt.lamps[0]    = 1'b0;
            nxt.relay       = 1'b0;
            if (acc_step == cur.stored_code) begin
              nxt.mode = MODE_ARMED;
              ev       = EV_ACCEPT;
            end else begin
              nxt.mode = MODE_IDLE;
              ev       = EV_REJECT;
            end
          end
        end
      end
      MODE_DISARM_ENTRY, MODE_ALARMED: begin
        if (digit_ok) begin
          took            = 1'b1;
          nxt.entry_acc   = acc_step;
          nxt.digit_count = cnt_step;
          if (done) begin
            nxt.entry_acc   = '0;
            nxt.digit_count = '0;
            if (acc_step == cur.stored_code) begin
              nxt.intrusion = 1'b0;
              nxt.lamps[0]  = 1'b0;
              nxt.relay     = 1'b0;
              nxt.buzzer    = 1'b0;
              nxt.mode      = MODE_IDLE;
              ev            = EV_ACCEPT;
            end else begin
              // wrong code: stay; disarm entry also drops the intrusion flag
              if (cur.mode == MODE_DISARM_ENTRY) begin
                nxt.intrusion = 1'b0;
              end
              ev = EV_REJECT;
            end
          end
        end
      end
      MODE_ARMED: begin
        if (key_code == KEY_F3) begin
          nxt.lamps[0] = 1'b0;
          nxt.mode     = MODE_DISARM_ENTRY;
        end
        // a pending intrusion wins over F3 on the same tick
        if (cur.intrusion) begin
          nxt.buzzer = 1'b1;
          nxt.relay  = 1'b1;
          nxt.mode   = MODE_ALARMED;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase

    if (nxt.mode == MODE_ARMED) begin
      nxt.lamps = zones;
      if (zones != 4'd0) begin
        nxt.intrusion = 1'b1;
      end
      nxt.buzzer = panic;
    end
  end

  always_comb begin
    if (took) begin
      shown = acc_step;
    end else if (nxt.mode == MODE_CHANGE) begin
      shown = nxt.new_acc;
    end else begin
      shown = nxt.entry_acc;
    end
  end

  assign res.panel_mode    = nxt.mode;
  assign res.entered_value = shown;
  assign res.event_code    = ev;
  assign res.zone_lamps    = nxt.lamps;
  assign res.buzzer_drive  = nxt.buzzer;
  assign res.alarm_relays  = nxt.relay;

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for keypad_alarm_panel_controller: scan ticks in, one panel result out.
// Predicts each result from an in-bench model of the panel and compares it field by field.
// Depends on kap_pkg and the keypad_alarm_panel_controller RTL.
`default_nettype none

module tb;
  import kap_pkg::*;

  localparam int QuietLimit = 3000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [3:0]          in_key_code = '0;
  logic                in_door_sensor = 1'b0;
  logic                in_dining_window = 1'b0;
  logic                in_dining_motion = 1'b0;
  logic                in_kitchen_window = 1'b0;
  logic                in_kitchen_motion = 1'b0;
  logic                in_bedroom_window = 1'b0;
  logic                in_bathroom_window = 1'b0;
  logic                in_panic_button = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [2:0]          out_panel_mode;
  logic [CodeW-1:0]    out_entered_value;
  logic [1:0]          out_event_code;
  logic [3:0]          out_zone_lamps;
  logic                out_buzzer_drive;
  logic                out_alarm_relays;

  kap_state_t          panel;
  kap_result_t         due_results[$];
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  errors = 0;
  int                  ticks_sent = 0;
  int                  results_checked = 0;
  int                  events_seen[4] = '{0, 0, 0, 0};
  logic [7:0]          modes_reached = '0;

  keypad_alarm_panel_controller i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_code       (in_key_code),
    .in_door_sensor    (in_door_sensor),
    .in_dining_window  (in_dining_window),
    .in_dining_motion  (in_dining_motion),
    .in_kitchen_window (in_kitchen_window),
    .in_kitchen_motion (in_kitchen_motion),
    .in_bedroom_window (in_bedroom_window),
    .in_bathroom_window(in_bathroom_window),
    .in_panic_button   (in_panic_button),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_panel_mode    (out_panel_mode),
    .out_entered_value (out_entered_value),
    .out_event_code    (out_event_code),
    .out_zone_lamps    (out_zone_lamps),
    .out_buzzer_drive  (out_buzzer_drive),
    .out_alarm_relays  (out_alarm_relays)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Sensor vector: [0] door, [1] dining window, [2] dining motion, [3] kitchen window,
  // [4] kitchen motion, [5] bedroom window, [6] bathroom window, [7] panic.
  function automatic kap_result_t advance_panel(logic [3:0] key, logic [7:0] sens);
    logic [3:0]       zones;
    logic [CodeW-1:0] shown;
    logic             took;
    logic             done;
    logic             match;
    event_t           ev;
    kap_result_t      r;
    zones = {sens[6], sens[5], sens[4] | sens[3], sens[2] | sens[1] | sens[0]};
    shown = '0;
    took  = 1'b0;
    done  = 1'b0;
    match = 1'b0;
    ev    = EV_NONE;
    case (panel.mode)
      MODE_IDLE: begin
        if (key == KEY_F1) begin
          panel.lamps[0] = 1'b0;
          panel.mode = MODE_ARM_ENTRY;
        end
        if (key == KEY_F2) begin
          panel.lamps[0] = 1'b0;
          panel.mode = MODE_PROGRAM;
        end
      end
      MODE_PROGRAM: begin
        if (key == KEY_F1) begin
          panel.lamps[0] = 1'b0;
          panel.mode = MODE_ZONES;
        end
        if (key == KEY_F2) begin
          panel.lamps[0] = 1'b0;
          panel.mode = MODE_CHANGE;
        end
        if (key == KEY_F3) begin
          panel.lamps[0] = 1'b0;
          panel.mode = MODE_IDLE;
        end
      end
      MODE_ZONES: begin
        // one tick only, whatever the key
        panel.lamps[2] = 1'b1;
        panel.mode = MODE_PROGRAM;
      end
      MODE_CHANGE: begin
        if (key < KEY_DIGIT_LIMIT && panel.digit_count < CODE_DIGITS) begin
          panel.new_acc = CodeW'(panel.new_acc * 10 + key);
          panel.digit_count = panel.digit_count + 3'd1;
          shown = panel.new_acc;
          took = 1'b1;
          if (panel.digit_count == CODE_DIGITS) begin
            panel.stored_code = panel.new_acc;
            panel.new_acc = '0;
            panel.digit_count = '0;
            ev = EV_CHANGED;
            panel.mode = MODE_PROGRAM;
          end
        end
      end
      MODE_ARM_ENTRY, MODE_DISARM_ENTRY, MODE_ALARMED: begin
        if (key < KEY_DIGIT_LIMIT && panel.digit_count < CODE_DIGITS) begin
          panel.entry_acc = CodeW'(panel.entry_acc * 10 + key);
          panel.digit_count = panel.digit_count + 3'd1;
          shown = panel.entry_acc;
          took = 1'b1;
          if (panel.digit_count == CODE_DIGITS) begin
            done = 1'b1;
            match = (panel.entry_acc == panel.stored_code);
            panel.entry_acc = '0;
            panel.digit_count = '0;
          end
        end
        if (done) begin
          if (panel.mode == MODE_ARM_ENTRY) begin
            panel.intrusion = 1'b0;
            panel.lamps[0] = 1'b0;
            panel.relay = 1'b0;
            panel.mode = match ? MODE_ARMED : MODE_IDLE;
            ev = match ? EV_ACCEPT : EV_REJECT;
          end else if (match) begin
            panel.intrusion = 1'b0;
            panel.lamps[0] = 1'b0;
            panel.relay = 1'b0;
            panel.buzzer = 1'b0;
            panel.mode = MODE_IDLE;
            ev = EV_ACCEPT;
          end else begin
            // a wrong code in alarmed mode leaves the intrusion flag alone
            if (panel.mode == MODE_DISARM_ENTRY) panel.intrusion = 1'b0;
            ev = EV_REJECT;
          end
        end
      end
      default: begin
        if (key == KEY_F3) begin
          panel.lamps[0] = 1'b0;
          panel.mode = MODE_DISARM_ENTRY;
        end
        // a pending intrusion wins over F3 on the same tick
        if (panel.intrusion) begin
          panel.buzzer = 1'b1;
          panel.relay = 1'b1;
          panel.mode = MODE_ALARMED;
        end
      end
    endcase
    if (panel.mode == MODE_ARMED) begin
      panel.lamps = zones;
      if (zones != 4'd0) panel.intrusion = 1'b1;
      panel.buzzer = sens[7];
    end
    if (!took) shown = (panel.mode == MODE_CHANGE) ? panel.new_acc : panel.entry_acc;
    r.panel_mode    = panel.mode;
    r.entered_value = shown;
    r.event_code    = ev;
    r.zone_lamps    = panel.lamps;
    r.buzzer_drive  = panel.buzzer;
    r.alarm_relays  = panel.relay;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= 20) $display("error at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d want %0d",
                                results_checked, name, got, want));
  endtask

  // Drive one tick at the falling edge, hold it until taken, then predict its result.
  task automatic send_tick(logic [3:0] key, logic [7:0] sens);
    kap_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid           <= 1'b1;
    in_key_code        <= key;
    in_door_sensor     <= sens[0];
    in_dining_window   <= sens[1];
    in_dining_motion   <= sens[2];
    in_kitchen_window  <= sens[3];
    in_kitchen_motion  <= sens[4];
    in_bedroom_window  <= sens[5];
    in_bathroom_window <= sens[6];
    in_panic_button    <= sens[7];
    do @(posedge clk); while (in_stall !== 1'b0);
    r = advance_panel(key, sens);
    due_results.push_back(r);
    ticks_sent++;
    events_seen[r.event_code]++;
    modes_reached[r.panel_mode] = 1'b1;
  endtask

  // Drop valid first so the last item is not taken again while waiting.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    kap_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        report_mismatch("result arrived with nothing outstanding");
      end else begin
        want = due_results.pop_front();
        check_field("panel_mode", out_panel_mode, want.panel_mode);
        check_field("entered_value", out_entered_value, want.entered_value);
        check_field("event_code", out_event_code, want.event_code);
        check_field("zone_lamps", out_zone_lamps, want.zone_lamps);
        check_field("buzzer_drive", out_buzzer_drive, want.buzzer_drive);
        check_field("alarm_relays", out_alarm_relays, want.alarm_relays);
      end
      results_checked++;
    end
  end

  // End the run if neither channel moves for too long.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QuietLimit) begin
        $display("watchdog: no handshake for %0d cycles", QuietLimit);
        $display("keypad_alarm_panel_controller: mismatch");
        $finish;
      end
    end
  end

  task automatic test_arm_and_alarm();
    send_tick(4'd5, 8'h00);     // digit in idle: ignored
    send_tick(4'd13, 8'hFF);    // unused key, sensors ignored outside armed
    send_tick(KEY_F1, 8'h00);
    send_tick(4'd1, 8'h00);
    send_tick(4'd2, 8'h00);
    send_tick(4'd3, 8'h00);
    send_tick(4'd4, 8'h00);     // reset code arms the panel
    send_tick(4'd15, 8'hFF);    // all zones and panic
    send_tick(KEY_F3, 8'h00);   // disarm request overridden by intrusion
    send_tick(4'd1, 8'h00);
    send_tick(4'd2, 8'h00);
    send_tick(4'd3, 8'h00);
    send_tick(4'd4, 8'h00);     // disarm clears buzzer and relays
  endtask

  task automatic test_program_and_change();
    send_tick(KEY_F2, 8'h00);
    send_tick(KEY_F1, 8'h00);   // zones
    send_tick(4'd14, 8'h00);    // back to program on any key
    send_tick(KEY_F2, 8'h00);   // change
    repeat (4) send_tick(4'd9, 8'h00);
    send_tick(KEY_F3, 8'h00);
    send_tick(KEY_F1, 8'h00);
    send_tick(4'd1, 8'h00);
    send_tick(4'd2, 8'h00);
    send_tick(4'd3, 8'h00);
    send_tick(4'd4, 8'h00);     // old code now rejected
  endtask

  // Pick a key that moves the panel along a plausible path from its current mode.
  task automatic send_session_tick();
    logic [3:0] key;
    logic [7:0] sens;
    int         pick;
    int         pos;
    int         scale;
    pick = $urandom_range(99);
    sens = 8'($urandom);
    key  = 4'($urandom);
    if (pick >= 10) begin
      case (panel.mode)
        MODE_IDLE:    key = (pick < 60) ? KEY_F1 : KEY_F2;
        MODE_PROGRAM: key = KEY_F1 + 4'($urandom_range(2));
        MODE_ZONES:   key = 4'($urandom);
        MODE_CHANGE: begin
          case ($urandom_range(3))
            0:       key = 4'd0;
            1:       key = 4'd9;
            default: key = 4'($urandom_range(9));
          endcase
        end
        MODE_ARMED: begin
          sens = 8'h00;
          if (pick < 30) sens = 8'(1 << $urandom_range(7));
          key = (pick >= 80) ? KEY_F3 : 4'd15;
        end
        default: begin
          // mostly the right digit of the stored code
          pos = int'(CODE_DIGITS) - 1 - int'(panel.digit_count);
          scale = 1;
          repeat (pos) scale *= 10;
          if (pick < 78) key = 4'((int'(panel.stored_code) / scale) % 10);
          else key = 4'($urandom_range(9));
        end
      endcase
    end
    send_tick(key, sens);
  endtask

  task automatic test_random_sessions(int count, int idle_pct, int stall_rate);
    send_idle_pct = idle_pct;
    stall_pct = stall_rate;
    for (int i = 0; i < count; i++) begin
      // hold off once per phase until the block has caught up
      if (i == count / 2) wait_drained();
      send_session_tick();
    end
  endtask

  initial begin
    panel = '0;
    panel.mode = MODE_IDLE;
    panel.stored_code = RESET_CODE;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    test_arm_and_alarm();
    test_program_and_change();
    test_random_sessions(200, 0, 0);
    test_random_sessions(200, 75, 0);
    test_random_sessions(200, 0, 75);
    test_random_sessions(200, 12, 12);

    @(negedge clk);
    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);
    if (due_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("covered %0d ticks, %0d results checked, %0d of 8 modes reached",
             ticks_sent, results_checked, $countones(modes_reached));
    $display("events: %0d accepted, %0d rejected, %0d code changes, %0d errors",
             events_seen[EV_ACCEPT], events_seen[EV_REJECT], events_seen[EV_CHANGED], errors);
    if (errors == 0) begin
      $display("keypad_alarm_panel_controller: match");
    end else begin
      $display("keypad_alarm_panel_controller: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
